/* rtl/wplt_pkg.sv */
// Package for the waypoint path length and time block: widths, speeds, states and control.
package wplt_pkg;

	// Default coordinate width, signed Q.8 metres.
	localparam int COORD_WIDTH_DEF = 24;

	// Widths of the result fields.
	localparam int DIST_W  = 25;
	localparam int TIME_W  = 20;
	localparam int SUM_W   = 40;
	localparam int SEL_W   = 2;
	localparam int SPEED_W = 8;

	// Cruise speed in metres per second for each aircraft select code.
	function automatic logic [SPEED_W-1:0] speed_of(input logic [SEL_W-1:0] sel);
		logic [SPEED_W-1:0] s;
		case (sel)
			2'd0:    s = 8'd188;
			2'd1:    s = 8'd39;
			2'd2:    s = 8'd250;
			2'd3:    s = 8'd57;
			default: s = 8'd188;
		endcase
		return s;
	endfunction

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_ADD,
		ST_ROOT,
		ST_DIV,
		ST_ACC_D,
		ST_ACC_T,
		ST_EMIT
	} state_t;

	// Control decoded from the state.
	typedef struct packed {
		logic in_stall;
		logic mul_y;
		logic sub_div;
		logic acc_time;
		logic emit;
	} ctl_t;

endpackage

/* rtl/waypoint_path_length_time.sv */
// Top level: waypoint leg length, leg time and saturating path totals.
//
// Channel  Direction  Handshake             Beat contents
// in       input      in_valid / in_stall   x_coord, y_coord, new_path
// out      output     out_valid / out_stall leg_distance, leg_time, total_distance, total_time
// cfg      input      cfg_write             cfg_data (aircraft select)
//
// A first point or a new-path point is only recorded and gives no result.
// A leg runs two squares on one multiplier, one add, a radix-2 square root and a
// restoring divide by the speed, both one bit per cycle on one shared subtractor,
// then two saturating adds on one adder.
// The output register is separate, so a new beat is taken while a result waits.
// Reset clears the sequencer, the previous point, the totals and the speed select.
module waypoint_path_length_time #(
	parameter int COORD_WIDTH = wplt_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [COORD_WIDTH-1:0]    x_coord,
	input  logic signed [COORD_WIDTH-1:0]    y_coord,
	input  logic                             new_path,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [wplt_pkg::DIST_W-1:0]      leg_distance,
	output logic [wplt_pkg::TIME_W-1:0]      leg_time,
	output logic [wplt_pkg::SUM_W-1:0]       total_distance,
	output logic [wplt_pkg::SUM_W-1:0]       total_time,
	input  logic                             cfg_write,
	input  logic [wplt_pkg::SEL_W-1:0]       cfg_data
);
	import wplt_pkg::*;

	// Root width covers the largest leg; the radicand holds two root widths.
	localparam int RW    = COORD_WIDTH + 1;
	localparam int RAD_W = 2 * RW;
	localparam int SUB_W = RW + 2;
	localparam int CNT_W = $clog2(RW);

	state_t state_q, state_d;
	ctl_t   ctl;

	logic [SEL_W-1:0]              sel_q;
	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
	logic                          have_point_q;
	logic [RW-1:0]                 mag_x_q, mag_y_q;
	logic [RAD_W-1:0]              rad_q, sq_q;
	logic [SUB_W-1:0]              rem_q;
	logic [RW-1:0]                 root_q, dist_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [SUM_W-1:0]              dist_sum_q, time_sum_q;
	logic                          out_valid_q;
	logic [DIST_W-1:0]             leg_distance_q;
	logic [TIME_W-1:0]             leg_time_q;
	logic [SUM_W-1:0]              total_distance_q, total_time_q;

	logic                          in_fire, leg_start, last_iter, out_free;
	logic signed [RW-1:0]          dx, dy;
	logic [RW-1:0]                 mul_a;
	logic [RAD_W-1:0]              product;
	logic [SUB_W-1:0]              sub_a, sub_b;
	logic [SUB_W:0]                diff;
	logic                          fits;
	logic [SUB_W-1:0]              sub_res;
	logic [SUM_W-1:0]              acc_a;
	logic [SUM_W:0]                acc_sum;
	logic [SUM_W-1:0]              acc_sat;
	logic [63:0]                   dist_ext, time_ext;

	// Handshake and sequencing conditions.
	assign in_fire   = in_valid && !ctl.in_stall;
	assign leg_start = in_fire && have_point_q && !new_path;
	assign last_iter = (cnt_q == '0);
	assign out_free  = !out_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (leg_start) state_d = ST_SQ_X;
			ST_SQ_X:  state_d = ST_SQ_Y;
			ST_SQ_Y:  state_d = ST_ADD;
			ST_ADD:   state_d = ST_ROOT;
			ST_ROOT:  if (last_iter) state_d = ST_DIV;
			ST_DIV:   if (last_iter) state_d = ST_ACC_D;
			ST_ACC_D: state_d = ST_ACC_T;
			ST_ACC_T: state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		ctl          = '0;
		ctl.in_stall = (state_q != ST_IDLE);
		ctl.mul_y    = (state_q == ST_SQ_Y);
		ctl.sub_div  = (state_q == ST_DIV);
		ctl.acc_time = (state_q == ST_ACC_T);
		ctl.emit     = (state_q == ST_EMIT) && out_free;
	end

	// Coordinate differences, one bit wider than the coordinates.
	assign dx = RW'(x_coord) - RW'(prev_x_q);
	assign dy = RW'(y_coord) - RW'(prev_y_q);

	// Shared multiplier, squares one magnitude per cycle.
	assign mul_a   = ctl.mul_y ? mag_y_q : mag_x_q;
	assign product = RAD_W'(mul_a) * RAD_W'(mul_a);

	// Shared subtractor: square root trial or divide step.
	always_comb begin
		if (ctl.sub_div) begin
			sub_a = SUB_W'({rem_q[SPEED_W-1:0], root_q[RW-1]});
			sub_b = SUB_W'(speed_of(sel_q));
		end else begin
			sub_a = {rem_q[RW-1:0], rad_q[RAD_W-1 -: 2]};
			sub_b = {root_q, 2'b01};
		end
		diff    = {1'b0, sub_a} - {1'b0, sub_b};
		fits    = !diff[SUB_W];
		sub_res = fits ? diff[SUB_W-1:0] : sub_a;
	end

	// Shared saturating adder for both totals.
	always_comb begin
		if (ctl.acc_time) begin
			acc_a   = time_sum_q;
			acc_sum = {1'b0, acc_a} + (SUM_W+1)'(root_q);
		end else begin
			acc_a   = dist_sum_q;
			acc_sum = {1'b0, acc_a} + (SUM_W+1)'(dist_q);
		end
		acc_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
	end

	assign dist_ext = 64'(dist_q);
	assign time_ext = 64'(root_q);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sel_q        <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			have_point_q <= 1'b0;
			dist_sum_q   <= '0;
			time_sum_q   <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				sel_q <= cfg_data;
			end
			if (in_fire) begin
				prev_x_q     <= x_coord;
				prev_y_q     <= y_coord;
				have_point_q <= 1'b1;
				if (new_path) begin
					dist_sum_q <= '0;
					time_sum_q <= '0;
				end
			end
			if (state_q == ST_ADD || (state_q == ST_ROOT && last_iter)) begin
				cnt_q <= CNT_W'(RW - 1);
			end else if (state_q == ST_ROOT || state_q == ST_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (state_q == ST_ACC_D) begin
				dist_sum_q <= acc_sat;
			end
			if (ctl.acc_time) begin
				time_sum_q <= acc_sat;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (leg_start) begin
			mag_x_q <= dx[RW-1] ? RW'(-dx) : RW'(dx);
			mag_y_q <= dy[RW-1] ? RW'(-dy) : RW'(dy);
		end
		case (state_q)
			ST_SQ_X: rad_q <= product;
			ST_SQ_Y: sq_q  <= product;
			ST_ADD: begin
				rad_q  <= rad_q + sq_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				root_q <= {root_q[RW-2:0], fits};
				if (last_iter) begin
					dist_q <= {root_q[RW-2:0], fits};
					rem_q  <= '0;
				end else begin
					rem_q <= sub_res;
				end
			end
			ST_DIV: begin
				rem_q  <= SUB_W'(sub_res[SPEED_W-1:0]);
				root_q <= {root_q[RW-2:0], fits};
			end
			default: begin
			end
		endcase
		if (ctl.emit) begin
			leg_distance_q   <= dist_ext[DIST_W-1:0];
			leg_time_q       <= time_ext[TIME_W-1:0];
			total_distance_q <= dist_sum_q;
			total_time_q     <= time_sum_q;
		end
	end

	assign in_stall       = ctl.in_stall;
	assign out_valid      = out_valid_q;
	assign leg_distance   = leg_distance_q;
	assign leg_time       = leg_time_q;
	assign total_distance = total_distance_q;
	assign total_time     = total_time_q;

endmodule

/* test/waypoint_path_length_time_test.sv */
// Self-checking testbench for waypoint_path_length_time with a leg scoreboard and random traffic.
module waypoint_path_length_time_test;
	timeunit 1ns;
	timeprecision 1ps;
	import wplt_pkg::*;

	localparam int CW             = COORD_WIDTH_DEF;
	localparam int LEG_CYCLES     = 2 * (CW + 1) + 6;
	localparam int SETTLE_CYCLES  = LEG_CYCLES + 10;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_BEATS    = 100;

	// Aircraft select codes, named by cruise speed.
	localparam logic [SEL_W-1:0] AC_SPD188 = 2'd0;
	localparam logic [SEL_W-1:0] AC_SPD39  = 2'd1;
	localparam logic [SEL_W-1:0] AC_SPD250 = 2'd2;
	localparam logic [SEL_W-1:0] AC_SPD57  = 2'd3;

	// Cruise speed in metres per second, indexed by select code.
	localparam int unsigned CRUISE_MPS [4] = '{188, 39, 250, 57};

	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [TIME_W-1:0] duration;
		logic [SUM_W-1:0]  dist_total;
		logic [SUM_W-1:0]  time_total;
	} leg_t;

	// Tracks the path state and the legs still owed by the block.
	class leg_scoreboard;
		logic signed [CW-1:0] last_x;
		logic signed [CW-1:0] last_y;
		bit                   have_point;
		logic [SUM_W-1:0]     dist_total;
		logic [SUM_W-1:0]     time_total;
		logic [SEL_W-1:0]     aircraft;
		leg_t                 expected_legs[$];
		int                   failures;

		function new();
			last_x     = '0;
			last_y     = '0;
			have_point = 0;
			dist_total = '0;
			time_total = '0;
			aircraft   = AC_SPD188;
			failures   = 0;
		endfunction

		// Running sum that holds at its maximum instead of wrapping.
		function logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] s, longint unsigned v);
			longint unsigned top;
			top = (64'd1 << SUM_W) - 64'd1;
			if (v >= top || s > top - v)
				return {SUM_W{1'b1}};
			return s + v[SUM_W-1:0];
		endfunction

		// Floor of the square root, one result bit per step.
		function longint unsigned root_floor(longint unsigned s);
			longint unsigned r;
			longint unsigned t;
			int              b;
			r = 0;
			for (b = 27; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= s)
					r = t;
			end
			return r;
		endfunction

		// Called for every accepted input beat.
		function void note_waypoint(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
				logic restart);
			longint          dx;
			longint          dy;
			longint unsigned ax;
			longint unsigned ay;
			longint unsigned leg_len;
			longint unsigned dur;
			leg_t            leg;
			// A first point or a restart only records the point.
			if (restart || !have_point) begin
				if (restart) begin
					dist_total = '0;
					time_total = '0;
				end
				last_x     = x;
				last_y     = y;
				have_point = 1;
				return;
			end
			dx      = longint'(x) - longint'(last_x);
			dy      = longint'(y) - longint'(last_y);
			ax      = (dx < 0) ? -dx : dx;
			ay      = (dy < 0) ? -dy : dy;
			leg_len = root_floor(ax * ax + ay * ay);
			dur     = leg_len / CRUISE_MPS[aircraft];
			dist_total = sat_sum(dist_total, leg_len);
			time_total = sat_sum(time_total, dur);
			last_x = x;
			last_y = y;
			leg.distance   = leg_len[DIST_W-1:0];
			leg.duration   = dur[TIME_W-1:0];
			leg.dist_total = dist_total;
			leg.time_total = time_total;
			expected_legs.push_back(leg);
		endfunction

		// Called for every accepted output beat.
		function void check_leg(leg_t got);
			leg_t want;
			if (expected_legs.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("Unexpected leg: dist %0d time %0d totals %0d %0d",
						got.distance, got.duration, got.dist_total, got.time_total);
				return;
			end
			want = expected_legs.pop_front();
			if (got.distance !== want.distance || got.duration !== want.duration ||
					got.dist_total !== want.dist_total ||
					got.time_total !== want.time_total) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("Leg mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
						want.distance, want.duration, want.dist_total, want.time_total,
						got.distance, got.duration, got.dist_total, got.time_total);
			end
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic signed [CW-1:0]   x_coord   = '0;
	logic signed [CW-1:0]   y_coord   = '0;
	logic                   new_path  = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [DIST_W-1:0]      leg_distance;
	logic [TIME_W-1:0]      leg_time;
	logic [SUM_W-1:0]       total_distance;
	logic [SUM_W-1:0]       total_time;
	logic                   cfg_write = 1'b0;
	logic [SEL_W-1:0]       cfg_data  = '0;

	leg_scoreboard        sb;
	bit                   quiet    = 0;
	bit                   hold_req = 0;
	int                   idle_cycles = 0;
	logic signed [CW-1:0] sent_x = '0;
	logic signed [CW-1:0] sent_y = '0;

	waypoint_path_length_time #(.COORD_WIDTH(CW)) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.x_coord        (x_coord),
		.y_coord        (y_coord),
		.new_path       (new_path),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.leg_distance   (leg_distance),
		.leg_time       (leg_time),
		.total_distance (total_distance),
		.total_time     (total_time),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data)
	);

	always #5ns clk = ~clk;

	// Offers one waypoint beat, after a random gap unless quiet, and returns once it is taken.
	task automatic send_waypoint(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic restart);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		x_coord  <= x;
		y_coord  <= y;
		new_path <= restart;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent_x = x;
		sent_y = y;
	endtask

	// Writes the aircraft select; only called while the block is idle.
	task automatic write_aircraft(input logic [SEL_W-1:0] sel);
		cfg_write <= 1'b1;
		cfg_data  <= sel;
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.aircraft = sel;
	endtask

	// Waits for every owed leg, then lets a point with no result finish too.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_legs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mix of full-range values, short hops, extremes and values near zero.
	function automatic logic signed [CW-1:0] pick_coord(logic signed [CW-1:0] near);
		logic [31:0] r;
		int          off;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return r[CW-1:0];
			4, 5, 6: begin
				off = int'($urandom_range(0, 8191)) - 4096;
				return near + off[CW-1:0];
			end
			7: return COORD_MAX;
			8: return COORD_MIN;
			default: begin
				off = int'($urandom_range(0, 2)) - 1;
				return off[CW-1:0];
			end
		endcase
	endfunction

	// Sample both channels at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_leg(leg_t'{leg_distance, leg_time, total_distance, total_time});
			if (in_valid && !in_stall)
				sb.note_waypoint(x_coord, y_coord, new_path);
		end
	end

	// Receiver: random stall per result beat, plus one long hold-off on request.
	initial begin
		int gap;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			gap = quiet ? 0 : $urandom_range(0, 8);
			out_stall <= (gap != 0);
			if (gap != 0) begin
				do @(posedge clk); while (!out_valid);
				repeat (gap) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus sequence.
	initial begin
		logic [SEL_W-1:0]     phase_sel [8];
		logic signed [CW-1:0] nx;
		logic signed [CW-1:0] ny;
		logic                 restart;
		int                   path_left;
		int                   p;
		int                   i;
		sb = new();
		phase_sel = '{AC_SPD250, AC_SPD39, AC_SPD57, AC_SPD188,
			AC_SPD57, AC_SPD250, AC_SPD39, AC_SPD188};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed legs under the reset speed: zero, extreme and exact lengths.
		send_waypoint('0, '0, 1'b0);
		send_waypoint('0, '0, 1'b0);
		send_waypoint(COORD_MAX, COORD_MAX, 1'b0);
		send_waypoint(COORD_MIN, COORD_MIN, 1'b0);
		send_waypoint(COORD_MAX, COORD_MIN, 1'b0);
		send_waypoint(COORD_MAX, COORD_MAX, 1'b0);
		send_waypoint(CW'(-1), CW'(-1), 1'b0);
		send_waypoint(CW'(100), CW'(-100), 1'b1);
		send_waypoint(CW'(356), CW'(-100), 1'b0);
		send_waypoint(CW'(1124), CW'(924), 1'b0);
		send_waypoint(CW'(1124), CW'(924), 1'b1);
		send_waypoint(COORD_MIN, COORD_MAX, 1'b1);
		send_waypoint(COORD_MAX, COORD_MIN, 1'b0);
		send_waypoint(COORD_MAX, COORD_MIN, 1'b0);
		send_waypoint('0, '0, 1'b1);
		send_waypoint(CW'(188), '0, 1'b0);
		send_waypoint(CW'(375), '0, 1'b0);
		drain();

		// One long diagonal pair under each of the other speeds, then the reset speed again.
		for (p = 1; p < 5; p++) begin
			write_aircraft(p[SEL_W-1:0]);
			send_waypoint(COORD_MIN, COORD_MIN, 1'b0);
			send_waypoint(COORD_MAX, COORD_MAX, 1'b0);
			drain();
		end

		// Random paths of random length, with stray restarts mixed in.
		path_left = 0;
		for (p = 0; p < 8; p++) begin
			write_aircraft(phase_sel[p]);
			quiet = (p == 2 || p == 4);
			if (p == 4)
				hold_req = 1;
			for (i = 0; i < PHASE_BEATS; i++) begin
				if (path_left == 0 || $urandom_range(0, 31) == 0) begin
					restart   = 1'b1;
					path_left = $urandom_range(1, 20);
				end else begin
					restart   = 1'b0;
					path_left--;
				end
				nx = pick_coord(sent_x);
				ny = pick_coord(sent_y);
				send_waypoint(nx, ny, restart);
			end
			drain();
		end

		if (sb.failures == 0 && sb.expected_legs.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* waypoint_path_length_time.f */
rtl/wplt_pkg.sv
rtl/waypoint_path_length_time.sv
test/waypoint_path_length_time_test.sv
